// ----- rtl/osc_source_message_parser_unit_assert.svh -----
// assertion macros for the osc message parser checker
// depends on clock and reset being visible where a macro is used
`ifndef OSC_SOURCE_MESSAGE_PARSER_UNIT_ASSERT_SVH
`define OSC_SOURCE_MESSAGE_PARSER_UNIT_ASSERT_SVH

// checked only outside reset
`define OSC_SMP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define OSC_SMP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/osc_smp_pkg.sv -----
// shared types, codes and constants of the osc message parser
// no dependencies
package osc_smp_pkg;

   localparam int MAX_ADDRESS_BYTES  = 16;
   localparam int RESULT_QUEUE_DEPTH = 4;
   localparam int TAG_LENGTH         = 9;

   // register indexes
   localparam logic [1:0] CSR_ADDRESS_LOW  = 2'd0;
   localparam logic [1:0] CSR_ADDRESS_HIGH = 2'd1;
   localparam logic [1:0] CSR_ADDRESS_LEN  = 2'd2;

   // result kinds
   localparam logic [3:0] KIND_ID          = 4'd0;
   localparam logic [3:0] KIND_CHAR        = 4'd1;
   localparam logic [3:0] KIND_FIRST_FLOAT = 4'd2;
   localparam logic [3:0] KIND_PORT        = 4'd8;
   localparam logic [3:0] KIND_OK          = 4'd9;
   localparam logic [3:0] KIND_ERROR       = 4'd10;

   // error codes
   localparam logic [31:0] ERR_ADDRESS   = 32'd0;
   localparam logic [31:0] ERR_TYPETAG   = 32'd1;
   localparam logic [31:0] ERR_TRUNCATED = 32'd2;

   localparam logic [2:0] FLOAT_COUNT = 3'd6;

   typedef enum logic [8:0] {
      PH_ADDR     = 9'b000000001,
      PH_ADDR_PAD = 9'b000000010,
      PH_TAG      = 9'b000000100,
      PH_TAG_PAD  = 9'b000001000,
      PH_ID       = 9'b000010000,
      PH_NAME     = 9'b000100000,
      PH_NAME_PAD = 9'b001000000,
      PH_FLOATS   = 9'b010000000,
      PH_PORT     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] value;
      logic        closing;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // expected type tag ",isffffffi"
   function automatic logic [7:0] tag_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h2c;
         4'd1:    ch = 8'h69;
         4'd2:    ch = 8'h73;
         4'd9:    ch = 8'h69;
         default: ch = 8'h66;
      endcase
      return ch;
   endfunction

   function automatic result_type make_close(input logic [3:0] kind,
                                             input logic [31:0] value);
      result_type r;
      r.kind    = kind;
      r.value   = value;
      r.closing = 1'b1;
      return r;
   endfunction

endpackage

// ----- rtl/osc_smp_core.sv -----
// per-byte parse state and result generation of the osc message parser
// depends on osc_smp_pkg
module osc_smp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             packet_byte,
   input  logic                   end_of_packet,
   input  logic [63:0]            address_low,
   input  logic [63:0]            address_high,
   input  logic [4:0]             address_length,
   output osc_smp_pkg::push_type  push
);

   osc_smp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  offset_ff, offset_in;
   logic [4:0]  index_ff, index_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  floats_ff, floats_in;
   logic        reply_ff, reply_in;
   logic        closed_ff, closed_in;

   logic                   field_v, close_v;
   osc_smp_pkg::result_type field_r, close_r;
   logic [1:0]  offset_next;
   logic [2:0]  floats_next;
   logic [127:0] address_all;
   logic [7:0]  expected;

   assign address_all = {address_high, address_low};
   assign expected    = address_all[{index_ff[3:0], 3'b000} +: 8];

   always_comb begin
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      index_in    = index_ff;
      shift_in    = shift_ff;
      floats_in   = floats_ff;
      reply_in    = reply_ff;
      closed_in   = closed_ff;
      field_v     = 1'b0;
      close_v     = 1'b0;
      field_r     = '0;
      close_r     = '0;
      offset_next = offset_ff + 2'd1;
      floats_next = floats_ff + 3'd1;

      if (!closed_ff) begin
         offset_in = offset_next;
         unique case (phase_ff)
            osc_smp_pkg::PH_ADDR: begin
               if (packet_byte == 8'd0) begin
                  if (index_ff == address_length) begin
                     index_in = '0;
                     phase_in = (offset_next != 2'd0) ? osc_smp_pkg::PH_ADDR_PAD
                                                     : osc_smp_pkg::PH_TAG;
                  end else begin
                     close_v = 1'b1;
                     close_r = osc_smp_pkg::make_close(osc_smp_pkg::KIND_ERROR,
                                                       osc_smp_pkg::ERR_ADDRESS);
                  end
               end else if (index_ff < address_length &&
                            index_ff < 5'(osc_smp_pkg::MAX_ADDRESS_BYTES) &&
                            packet_byte == expected) begin
                  index_in = index_ff + 5'd1;
               end else begin
                  close_v = 1'b1;
                  close_r = osc_smp_pkg::make_close(osc_smp_pkg::KIND_ERROR,
                                                    osc_smp_pkg::ERR_ADDRESS);
               end
            end
            osc_smp_pkg::PH_ADDR_PAD: begin
               if (offset_next == 2'd0) phase_in = osc_smp_pkg::PH_TAG;
            end
            osc_smp_pkg::PH_TAG: begin
               if (index_ff < 5'(osc_smp_pkg::TAG_LENGTH)) begin
                  if (packet_byte == osc_smp_pkg::tag_char(index_ff[3:0])) begin
                     index_in = index_ff + 5'd1;
                  end else begin
                     close_v = 1'b1;
                     close_r = osc_smp_pkg::make_close(osc_smp_pkg::KIND_ERROR,
                                                       osc_smp_pkg::ERR_TYPETAG);
                  end
               end else if (index_ff == 5'(osc_smp_pkg::TAG_LENGTH) &&
                            packet_byte == osc_smp_pkg::tag_char(index_ff[3:0])) begin
                  reply_in = 1'b1;
                  index_in = index_ff + 5'd1;
               end else if (packet_byte == 8'd0) begin
                  index_in = '0;
                  phase_in = (offset_next != 2'd0) ? osc_smp_pkg::PH_TAG_PAD
                                                  : osc_smp_pkg::PH_ID;
               end else begin
                  close_v = 1'b1;
                  close_r = osc_smp_pkg::make_close(osc_smp_pkg::KIND_ERROR,
                                                    osc_smp_pkg::ERR_TYPETAG);
               end
            end
            osc_smp_pkg::PH_TAG_PAD: begin
               if (offset_next == 2'd0) phase_in = osc_smp_pkg::PH_ID;
            end
            osc_smp_pkg::PH_ID: begin
               shift_in = {shift_ff[23:0], packet_byte};
               if (offset_next == 2'd0) begin
                  field_v  = 1'b1;
                  field_r  = '{kind: osc_smp_pkg::KIND_ID, value: shift_in, closing: 1'b0};
                  phase_in = osc_smp_pkg::PH_NAME;
               end
            end
            osc_smp_pkg::PH_NAME: begin
               if (packet_byte == 8'd0) begin
                  phase_in = (offset_next != 2'd0) ? osc_smp_pkg::PH_NAME_PAD
                                                  : osc_smp_pkg::PH_FLOATS;
               end else begin
                  field_v = 1'b1;
                  field_r = '{kind: osc_smp_pkg::KIND_CHAR, value: 32'(packet_byte),
                              closing: 1'b0};
               end
            end
            osc_smp_pkg::PH_NAME_PAD: begin
               if (offset_next == 2'd0) phase_in = osc_smp_pkg::PH_FLOATS;
            end
            osc_smp_pkg::PH_FLOATS: begin
               shift_in = {shift_ff[23:0], packet_byte};
               if (offset_next == 2'd0) begin
                  field_v   = 1'b1;
                  field_r   = '{kind: osc_smp_pkg::KIND_FIRST_FLOAT + 4'(floats_ff),
                                value: shift_in, closing: 1'b0};
                  floats_in = floats_next;
                  if (floats_next >= osc_smp_pkg::FLOAT_COUNT) begin
                     if (reply_ff) begin
                        phase_in = osc_smp_pkg::PH_PORT;
                     end else begin
                        close_v = 1'b1;
                        close_r = osc_smp_pkg::make_close(osc_smp_pkg::KIND_OK, '0);
                     end
                  end
               end
            end
            osc_smp_pkg::PH_PORT: begin
               shift_in = {shift_ff[23:0], packet_byte};
               if (offset_next == 2'd0) begin
                  field_v = 1'b1;
                  field_r = '{kind: osc_smp_pkg::KIND_PORT, value: shift_in, closing: 1'b0};
                  close_v = 1'b1;
                  close_r = osc_smp_pkg::make_close(osc_smp_pkg::KIND_OK, '0);
               end
            end
            default: begin
               closed_in = 1'b1;
            end
         endcase

         if (close_v) closed_in = 1'b1;
         // packet ended before the last argument
         if (end_of_packet && !closed_in) begin
            close_v   = 1'b1;
            close_r   = osc_smp_pkg::make_close(osc_smp_pkg::KIND_ERROR,
                                                osc_smp_pkg::ERR_TRUNCATED);
            closed_in = 1'b1;
         end
      end

      if (end_of_packet) begin
         phase_in  = osc_smp_pkg::PH_ADDR;
         offset_in = '0;
         index_in  = '0;
         floats_in = '0;
         reply_in  = 1'b0;
         closed_in = 1'b0;
      end
   end

   always_comb begin
      push.count  = {1'b0, field_v} + {1'b0, close_v};
      push.first  = field_v ? field_r : close_r;
      push.second = close_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= osc_smp_pkg::PH_ADDR;
         offset_ff <= '0;
         index_ff  <= '0;
         floats_ff <= '0;
         reply_ff  <= 1'b0;
         closed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         index_ff  <= index_in;
         floats_ff <= floats_in;
         reply_ff  <= reply_in;
         closed_ff <= closed_in;
      end
   end

   // word assembly, every word is fully refilled before use
   always_ff @(posedge clock) begin
      if (accept) shift_ff <= shift_in;
   end

endmodule

// ----- rtl/osc_smp_queue.sv -----
// result queue of the osc message parser, takes up to two results a cycle
// depends on osc_smp_pkg
module osc_smp_queue #(
   parameter int DEPTH = osc_smp_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_en,
   input  osc_smp_pkg::push_type   push,
   input  logic                    pop,
   output logic                    has_room,
   output logic                    out_valid,
   output osc_smp_pkg::result_type out_result
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   osc_smp_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       n_push;

   assign n_push     = push_en ? push.count : 2'd0;
   assign wr_in      = wr_ff + PTR_W'(n_push);
   assign rd_in      = rd_ff + PTR_W'(pop);
   assign cnt_in     = cnt_ff + CNT_W'(n_push) - CNT_W'(pop);
   assign has_room   = cnt_ff <= CNT_W'(DEPTH - 2);
   assign out_valid  = cnt_ff != '0;
   assign out_result = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wr_ff] <= push.first;
      if (n_push == 2'd2) mem_ff[wr_ff + PTR_W'(1)] <= push.second;
   end

endmodule

// ----- rtl/osc_source_message_parser_unit.sv -----
// osc message parser, top level
// holds the address registers, instantiates osc_smp_core and osc_smp_queue
//
// usage
//  - req_ channel: one message byte per transaction with an end-of-packet
//    flag; a new transaction may be taken every cycle while req_ready is high
//  - rsp_ channel: parsed fields in message order (id, name characters,
//    six float bit patterns, optional reply port), then one ok or error
//    transaction with rsp_final_result set
//  - csr_ channel: address register writes, always ready, index 0 and 1
//    the expected address bytes, index 2 the address length
//  - a result is registered in the result queue when its byte is taken and shows on rsp_ once it is at the head
//  - throughput: one byte per cycle while req_ready is high; a byte yields up to two results,
//    which leave the result queue one per cycle while rsp_ready is high
//  - req_ready drops when the result queue has fewer than two free
//    entries, so a stalled receiver backs up into the sender after the
//    queue depth is used up
//  - reset clears the parse state, the queue and the address registers
module osc_source_message_parser_unit #(
   parameter int RESULT_DEPTH = osc_smp_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_end_of_packet,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_field_kind,
   output logic [31:0] rsp_field_value,
   output logic        rsp_final_result,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] addr_low_ff;
   logic [63:0] addr_high_ff;
   logic [4:0]  addr_len_ff;

   logic                    accept;
   logic                    room;
   osc_smp_pkg::push_type   push;
   osc_smp_pkg::result_type head;

   // registers take effect from the next byte
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_low_ff  <= '0;
         addr_high_ff <= '0;
         addr_len_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            osc_smp_pkg::CSR_ADDRESS_LOW:  addr_low_ff  <= csr_data;
            osc_smp_pkg::CSR_ADDRESS_HIGH: addr_high_ff <= csr_data;
            osc_smp_pkg::CSR_ADDRESS_LEN:  addr_len_ff  <= csr_data[4:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // byte taken while the queue can absorb the worst case of two results
   assign req_ready = room;
   assign accept    = req_valid & room;

   osc_smp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .packet_byte    (req_packet_byte),
      .end_of_packet  (req_end_of_packet),
      .address_low    (addr_low_ff),
      .address_high   (addr_high_ff),
      .address_length (addr_len_ff),
      .push           (push)
   );

   osc_smp_queue #(
      .DEPTH (RESULT_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (accept),
      .push       (push),
      .pop        (rsp_valid & rsp_ready),
      .has_room   (room),
      .out_valid  (rsp_valid),
      .out_result (head)
   );

   // head of queue drives the result ports directly
   assign rsp_field_kind   = head.kind;
   assign rsp_field_value  = head.value;
   assign rsp_final_result = head.closing;

endmodule

// ----- rtl/osc_smp_checker.sv -----
// port-level checks of the osc message parser, bound to the top level
// depends on osc_smp_pkg and osc_source_message_parser_unit_assert.svh
`include "osc_source_message_parser_unit_assert.svh"

module osc_smp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_field_kind,
   input logic [31:0] rsp_field_value,
   input logic        rsp_final_result
);

   // kind of the result on the port
   logic ok_kind;
   logic closing_kind;

   assign ok_kind      = rsp_field_kind == osc_smp_pkg::KIND_OK;
   assign closing_kind = ok_kind || rsp_field_kind == osc_smp_pkg::KIND_ERROR;

   // result transaction held while stalled
   `OSC_SMP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

   // closing flag exactly on ok and error
   `OSC_SMP_ASSERT(a_final_kind, rsp_valid |-> rsp_final_result == closing_kind, "bad closing flag")

   // ok carries a zero value
   `OSC_SMP_ASSERT(a_ok_zero, rsp_valid && ok_kind |-> rsp_field_value == 32'd0, "ok not zero")

   // queue empty after reset
   `OSC_SMP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind osc_source_message_parser_unit osc_smp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_field_kind   (rsp_field_kind),
   .rsp_field_value  (rsp_field_value),
   .rsp_final_result (rsp_final_result)
);

// ----- bench/osc_source_message_parser_unit_checker.sv -----
`timescale 1ns / 100ps
// field checker for the osc message parser: follows every byte, result and csr transaction
// keeps its own parse of each message and compares every result field in order
// depends on osc_smp_pkg for the result struct, phase names, kinds and codes
module osc_source_message_parser_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_end_of_packet,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_field_kind,
   input  logic [31:0] rsp_field_value,
   input  logic        rsp_final_result,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          mismatch_count,
   output int          pending_results
);

   localparam logic [79:0] TAG_TEXT = ",isffffffi";

   // address registers as last written
   logic [63:0] addr_low;
   logic [63:0] addr_high;
   logic [4:0]  addr_len;

   // parse state
   osc_smp_pkg::phase_type phase;
   logic [1:0]  offset;
   logic [4:0]  str_idx;
   logic [31:0] word;
   logic [2:0]  float_idx;
   logic        reply_tag;
   logic        closed;

   osc_smp_pkg::result_type expected_fields[$];
   osc_smp_pkg::result_type want;
   int          emitted;

   function automatic logic [7:0] address_char(input logic [4:0] i);
      logic [127:0] all;
      all = {addr_high, addr_low} >> {i[3:0], 3'b000};
      return all[7:0];
   endfunction

   function automatic logic [7:0] tag_char_at(input logic [4:0] i);
      logic [79:0] t;
      t = TAG_TEXT << (8 * i);
      return t[79:72];
   endfunction

   // a byte never yields more than two results
   task automatic emit(input logic [3:0] kind, input logic [31:0] value, input logic closing);
      osc_smp_pkg::result_type r;
      if (emitted < 2) begin
         r.kind    = kind;
         r.value   = value;
         r.closing = closing;
         expected_fields.push_back(r);
      end
      emitted++;
   endtask

   task automatic close_msg(input logic [3:0] kind, input logic [31:0] value);
      emit(kind, value, 1'b1);
      closed = 1'b1;
   endtask

   task automatic clear_msg();
      phase     = osc_smp_pkg::PH_ADDR;
      offset    = '0;
      str_idx   = '0;
      word      = '0;
      float_idx = '0;
      reply_tag = 1'b0;
      closed    = 1'b0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eop);
      logic tag_done;
      tag_done = 1'b0;
      emitted  = 0;
      if (!closed) begin
         offset = offset + 2'd1;
         case (phase)
            osc_smp_pkg::PH_ADDR: begin
               if (b == 8'h00) begin
                  if (str_idx == addr_len) begin
                     str_idx = '0;
                     phase   = (offset != 2'd0) ? osc_smp_pkg::PH_ADDR_PAD
                                                : osc_smp_pkg::PH_TAG;
                  end else begin
                     close_msg(osc_smp_pkg::KIND_ERROR, osc_smp_pkg::ERR_ADDRESS);
                  end
               end else if (str_idx < addr_len && str_idx < osc_smp_pkg::MAX_ADDRESS_BYTES &&
                            b == address_char(str_idx)) begin
                  str_idx++;
               end else begin
                  close_msg(osc_smp_pkg::KIND_ERROR, osc_smp_pkg::ERR_ADDRESS);
               end
            end
            osc_smp_pkg::PH_ADDR_PAD: begin
               if (offset == 2'd0) phase = osc_smp_pkg::PH_TAG;
            end
            osc_smp_pkg::PH_TAG: begin
               if (str_idx < 5'd9) begin
                  if (b == tag_char_at(str_idx)) str_idx++;
                  else close_msg(osc_smp_pkg::KIND_ERROR, osc_smp_pkg::ERR_TYPETAG);
               end else if (str_idx == 5'd9) begin
                  if (b == tag_char_at(5'd9)) begin
                     reply_tag = 1'b1;
                     str_idx   = 5'd10;
                  end else if (b == 8'h00) begin
                     tag_done = 1'b1;
                  end else begin
                     close_msg(osc_smp_pkg::KIND_ERROR, osc_smp_pkg::ERR_TYPETAG);
                  end
               end else begin
                  if (b == 8'h00) tag_done = 1'b1;
                  else close_msg(osc_smp_pkg::KIND_ERROR, osc_smp_pkg::ERR_TYPETAG);
               end
               if (tag_done) begin
                  str_idx = '0;
                  phase   = (offset != 2'd0) ? osc_smp_pkg::PH_TAG_PAD : osc_smp_pkg::PH_ID;
               end
            end
            osc_smp_pkg::PH_TAG_PAD: begin
               if (offset == 2'd0) phase = osc_smp_pkg::PH_ID;
            end
            osc_smp_pkg::PH_ID: begin
               word = {word[23:0], b};
               if (offset == 2'd0) begin
                  emit(osc_smp_pkg::KIND_ID, word, 1'b0);
                  phase = osc_smp_pkg::PH_NAME;
               end
            end
            osc_smp_pkg::PH_NAME: begin
               if (b == 8'h00) phase = (offset != 2'd0) ? osc_smp_pkg::PH_NAME_PAD
                                                        : osc_smp_pkg::PH_FLOATS;
               else emit(osc_smp_pkg::KIND_CHAR, {24'd0, b}, 1'b0);
            end
            osc_smp_pkg::PH_NAME_PAD: begin
               if (offset == 2'd0) phase = osc_smp_pkg::PH_FLOATS;
            end
            osc_smp_pkg::PH_FLOATS: begin
               word = {word[23:0], b};
               if (offset == 2'd0) begin
                  emit(osc_smp_pkg::KIND_FIRST_FLOAT + {1'b0, float_idx}, word, 1'b0);
                  float_idx = float_idx + 3'd1;
                  if (float_idx >= osc_smp_pkg::FLOAT_COUNT) begin
                     if (reply_tag) phase = osc_smp_pkg::PH_PORT;
                     else close_msg(osc_smp_pkg::KIND_OK, 32'd0);
                  end
               end
            end
            osc_smp_pkg::PH_PORT: begin
               word = {word[23:0], b};
               if (offset == 2'd0) begin
                  emit(osc_smp_pkg::KIND_PORT, word, 1'b0);
                  close_msg(osc_smp_pkg::KIND_OK, 32'd0);
               end
            end
            default: closed = 1'b1;
         endcase
         if (eop && !closed) close_msg(osc_smp_pkg::KIND_ERROR, osc_smp_pkg::ERR_TRUNCATED);
      end
      if (eop) clear_msg();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         addr_low        = '0;
         addr_high       = '0;
         addr_len        = '0;
         clear_msg();
         expected_fields.delete();
         mismatch_count  = 0;
      end else begin
         // results first: a byte taken at this edge cannot have its result out yet
         if (rsp_valid && rsp_ready) begin
            if (expected_fields.size() == 0) begin
               $error("result with none expected: kind %0d value %h",
                      rsp_field_kind, rsp_field_value);
               mismatch_count++;
            end else begin
               want = expected_fields.pop_front();
               if (rsp_field_kind !== want.kind) begin
                  $error("field_kind: expected %0d, actual %0d", want.kind, rsp_field_kind);
                  mismatch_count++;
               end
               if (rsp_field_value !== want.value) begin
                  $error("field_value: expected %h, actual %h", want.value, rsp_field_value);
                  mismatch_count++;
               end
               if (rsp_final_result !== want.closing) begin
                  $error("final_result: expected %0d, actual %0d",
                         want.closing, rsp_final_result);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               osc_smp_pkg::CSR_ADDRESS_LOW:  addr_low  = csr_data;
               osc_smp_pkg::CSR_ADDRESS_HIGH: addr_high = csr_data;
               osc_smp_pkg::CSR_ADDRESS_LEN:  addr_len  = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) parse_byte(req_packet_byte, req_end_of_packet);
      end
      pending_results = expected_fields.size();
   end

endmodule

// ----- bench/osc_source_message_parser_unit_tb.sv -----
`timescale 1ns / 100ps
// top of the osc message parser bench: clock, reset, byte and csr stimulus, receiver stalls
// depends on osc_smp_pkg, osc_source_message_parser_unit and the field checker
module osc_source_message_parser_unit_tb;

   // index 3 is not a register, writes to it must change nothing
   localparam logic [1:0]  CSR_UNUSED    = 2'd3;
   localparam logic [71:0] TAG_BASE      = ",isffffff";
   localparam logic [7:0]  TAG_REPLY     = "i";
   localparam int          ITEM_TARGET   = 1950;
   localparam int          PHASE_BUDGET  = 300;
   localparam int          BAD_LEN_BUDGET = 80;
   localparam int          HOLD_AFTER    = 800;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          DRAIN_CYCLES  = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_packet_byte;
   logic        req_end_of_packet;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_field_kind;
   logic [31:0] rsp_field_value;
   logic        rsp_final_result;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   int          mismatch_count;
   int          pending_results;
   int          bytes_sent;

   // the address as the bench last wrote it, used to build matching messages
   logic [63:0] cfg_low;
   logic [63:0] cfg_high;
   logic [4:0]  cfg_len;

   logic [7:0]  message[$];

   osc_source_message_parser_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_packet_byte   (req_packet_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_field_value   (rsp_field_value),
      .rsp_final_result  (rsp_final_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   osc_source_message_parser_unit_checker field_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_packet_byte   (req_packet_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_field_value   (rsp_field_value),
      .rsp_final_result  (rsp_final_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .pending_results   (pending_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // mostly no gap, sometimes a few cycles, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 93) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // every byte nonzero so that a matching address can be sent
   function automatic logic [63:0] nonzero_bytes();
      logic [63:0] v;
      for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(1, 255));
      return v;
   endfunction

   // one byte transaction; payload changes only at the falling edge
   task automatic send_byte(input logic [7:0] b, input logic eop, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_packet_byte   <= b;
      req_end_of_packet <= eop;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_message();
      bit burst;
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < message.size(); k++)
         send_byte(message[k], k == message.size() - 1, burst ? 0 : pick_gap());
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all expected results out, then a few more cycles for bytes with no result
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // fill up to the next 4-byte boundary, pad values are not checked
   task automatic pad_random();
      while (message.size() % 4 != 0) message.push_back(8'($urandom_range(0, 255)));
   endtask

   // a well-formed message for the current address, then maybe damaged
   task automatic build_message();
      logic [127:0] addr_all;
      logic         reply;
      int           pick;
      int           cut;
      addr_all = {cfg_high, cfg_low};
      message.delete();
      for (int k = 0; k < cfg_len && k < osc_smp_pkg::MAX_ADDRESS_BYTES; k++)
         message.push_back(addr_all[8*k +: 8]);
      message.push_back(8'h00);
      pad_random();
      reply = 1'($urandom_range(0, 1));
      for (int k = 0; k < 9; k++) message.push_back(TAG_BASE[71 - 8*k -: 8]);
      if (reply) message.push_back(TAG_REPLY);
      message.push_back(8'h00);
      pad_random();
      repeat (4) message.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 7)) message.push_back(8'($urandom_range(1, 255)));
      message.push_back(8'h00);
      pad_random();
      repeat (24) message.push_back(8'($urandom_range(0, 255)));
      if (reply) repeat (4) message.push_back(8'($urandom_range(0, 255)));
      // trailing bytes after the last field are ignored
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) message.push_back(8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // truncated packet
         cut = $urandom_range(1, message.size() - 1);
         while (message.size() > cut) void'(message.pop_back());
      end else if (pick < 30) begin
         // one byte replaced anywhere
         message[$urandom_range(0, message.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 40) begin
         // plain noise
         message.delete();
         repeat ($urandom_range(1, 10)) message.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // special cases with an empty address
   task automatic run_directed();
      // address null with end of packet: truncated
      message = '{8'h00};
      send_message();
      // early address mismatch, then end of packet while closed
      message = '{8'h41, 8'h00};
      send_message();
      // odd pad values, type tag broken on its third character
      message = '{8'h00, 8'hff, 8'h80, 8'h01, ",", "i", "x", 8'hff};
      send_message();
      // type tag one character too long
      message = '{8'h00, 8'h00, 8'h00, 8'h00, ",", "i", "s", "f", "f", "f", "f", "f", "f",
                  "i", "i"};
      send_message();
   endtask

   // receiver: clean and choppy stretches, plus one long hold-off to back up the block
   initial begin
      int  stall_left;
      int  mode_left;
      bit  choppy;
      bit  hold_done;
      stall_left = 0;
      mode_left  = 0;
      choppy     = 1'b0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            choppy    = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(20, 100);
         end
         mode_left--;
         if (!hold_done && bytes_sent >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (choppy) stall_left = pick_gap();
         end
      end
   end

   // stimulus: one address setting per phase, directed cases first, then random messages
   initial begin
      int          phase_no;
      int          phase_start;
      int          budget;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] len_word;
      int          r;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_packet_byte   = '0;
      req_end_of_packet = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      bytes_sent        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      phase_no = 0;
      while (bytes_sent < ITEM_TARGET) begin
         budget = PHASE_BUDGET;
         case (phase_no)
            0: begin
               // all zero, empty address
               lo       = '0;
               hi       = '0;
               len_word = '0;
            end
            1: begin
               // all ones, full sixteen-byte address, upper length bits set
               lo       = '1;
               hi       = '1;
               len_word = 64'hffff_ffff_ffff_fff0;
            end
            2: begin
               // length beyond the address store: nothing may match
               lo       = nonzero_bytes();
               hi       = nonzero_bytes();
               len_word = {$urandom, $urandom};
               len_word[4:0] = 5'($urandom_range(17, 31));
               budget   = BAD_LEN_BUDGET;
            end
            default: begin
               lo       = nonzero_bytes();
               hi       = nonzero_bytes();
               len_word = {$urandom, $urandom};
               r        = $urandom_range(0, 9);
               if (r == 0) len_word[4:0] = 5'd0;
               else if (r == 1) len_word[4:0] = 5'd16;
               else len_word[4:0] = 5'($urandom_range(1, 15));
            end
         endcase
         if (phase_no > 0) wait_idle();
         write_csr(osc_smp_pkg::CSR_ADDRESS_LOW, lo);
         write_csr(osc_smp_pkg::CSR_ADDRESS_HIGH, hi);
         write_csr(osc_smp_pkg::CSR_ADDRESS_LEN, len_word);
         if (phase_no == 1) write_csr(CSR_UNUSED, {$urandom, $urandom});
         cfg_low  = lo;
         cfg_high = hi;
         cfg_len  = len_word[4:0];

         if (phase_no == 0) run_directed();
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < budget && bytes_sent < ITEM_TARGET) begin
            build_message();
            send_message();
         end
         phase_no++;
      end

      // drain whatever is still owed, then settle
      wait_idle();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
